@@ rtl/core/radio_module_frame_parser_unit_assert.svh @@
// Assertion macros for the radio module frame parser.
`ifndef RADIO_MODULE_FRAME_PARSER_UNIT_ASSERT_SVH
`define RADIO_MODULE_FRAME_PARSER_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define RMFP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rmfp assertion failed");

// Consequent checked in the cycle after the antecedent.
`define RMFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rmfp assertion failed");

`endif

@@ rtl/core/rmfp_pkg.sv @@
`default_nettype none

package rmfp_pkg;

  localparam logic [7:0] START_BYTE        = 8'h02;
  localparam logic [7:0] DATA_OPCODE       = 8'h81;
  localparam logic [7:0] READ_OPCODE       = 8'h4a;
  localparam logic [7:0] LEN_OVERHEAD      = 8'd5;
  localparam int unsigned REPLY_HEADER_BYTES = 4;
  localparam logic [7:0] READ_BYTE_INDEX   = 8'd2;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_OPCODE     = 4'd1,
    ST_REPLY_LEN  = 4'd2,
    ST_REPLY_DATA = 4'd3,
    ST_DATA_LEN   = 4'd4,
    ST_SOURCE     = 4'd5,
    ST_DEST       = 4'd6,
    ST_TYPE       = 4'd7,
    ST_PAYLOAD    = 4'd8,
    ST_PRIORITY   = 4'd9,
    ST_STRENGTH   = 4'd10,
    ST_CHECK      = 4'd11
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_REPLY_DONE = 2'd1,
    KIND_REPLY_DROP = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] source_id;
    logic [7:0] dest_id;
    logic [7:0] msg_type;
    logic [7:0] msg_priority;
    logic [7:0] payload_byte;
    logic       last_byte;
    logic [7:0] reply_opcode;
    logic       read_valid;
    logic [7:0] read_value;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/rmfp_intf.sv @@
`default_nettype none

interface rmfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rmfp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] source_id;
  logic [7:0] dest_id;
  logic [7:0] msg_type;
  logic [7:0] msg_priority;
  logic [7:0] payload_byte;
  logic       last_byte;
  logic [7:0] reply_opcode;
  logic       read_valid;
  logic [7:0] read_value;

  modport source (
    output valid, output kind, output source_id, output dest_id, output msg_type,
    output msg_priority, output payload_byte, output last_byte, output reply_opcode,
    output read_valid, output read_value, input ready
  );
  modport sink (
    input valid, input kind, input source_id, input dest_id, input msg_type,
    input msg_priority, input payload_byte, input last_byte, input reply_opcode,
    input read_valid, input read_value, output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/rmfp_parser.sv @@
`default_nettype none

module rmfp_parser #(
  parameter int unsigned REPLY_BUFFER_BYTES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        byte_i,
  output logic                   res_valid_o,
  output rmfp_pkg::result_t      res_o
);
  import rmfp_pkg::*;

  // Largest reply length that still fits the reply buffer.
  localparam logic [7:0] REPLY_LIMIT = 8'(REPLY_BUFFER_BYTES - REPLY_HEADER_BYTES);

  parse_state_e st_q, st_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] pay_len_q, pay_len_d;
  logic [7:0] rep_len_q, rep_len_d;
  logic [7:0] opcode_q, opcode_d;
  logic [7:0] src_q, src_d;
  logic [7:0] dst_q, dst_d;
  logic [7:0] typ_q, typ_d;
  logic [7:0] prio_q, prio_d;
  logic [7:0] third_q, third_d;
  logic [7:0] cnt_inc;
  logic       reply_big;

  assign cnt_inc   = cnt_q + 8'd1;
  assign reply_big = byte_i > REPLY_LIMIT;

  // Next state
  always_comb begin
    st_d = st_q;
    if (accept_i) begin
      case (st_q)
        ST_IDLE:       if (byte_i == START_BYTE) st_d = ST_OPCODE;
        ST_OPCODE:     st_d = (byte_i == DATA_OPCODE) ? ST_DATA_LEN : ST_REPLY_LEN;
        ST_REPLY_LEN: begin
          if (reply_big || byte_i == 8'd0) st_d = ST_CHECK;
          else                              st_d = ST_REPLY_DATA;
        end
        ST_REPLY_DATA: if (cnt_inc >= rep_len_q) st_d = ST_CHECK;
        ST_DATA_LEN:   st_d = ST_SOURCE;
        ST_SOURCE:     st_d = ST_DEST;
        ST_DEST:       st_d = ST_TYPE;
        ST_TYPE:       st_d = ST_PRIORITY;
        ST_PRIORITY:   st_d = (pay_len_q != 8'd0) ? ST_PAYLOAD : ST_STRENGTH;
        ST_PAYLOAD:    if (cnt_inc >= pay_len_q) st_d = ST_STRENGTH;
        ST_STRENGTH:   st_d = ST_CHECK;
        ST_CHECK:      st_d = ST_IDLE;
        default:       st_d = ST_IDLE;
      endcase
    end
  end

  // Held header and counter registers
  always_comb begin
    cnt_d     = cnt_q;
    pay_len_d = pay_len_q;
    rep_len_d = rep_len_q;
    opcode_d  = opcode_q;
    src_d     = src_q;
    dst_d     = dst_q;
    typ_d     = typ_q;
    prio_d    = prio_q;
    third_d   = third_q;
    if (accept_i) begin
      case (st_q)
        ST_IDLE:       if (byte_i == START_BYTE) cnt_d = 8'd0;
        ST_OPCODE:     if (byte_i != DATA_OPCODE) opcode_d = byte_i;
        ST_REPLY_LEN:  if (!reply_big) rep_len_d = byte_i;
        ST_REPLY_DATA: begin
          if (cnt_q == READ_BYTE_INDEX) third_d = byte_i;
          cnt_d = cnt_inc;
        end
        ST_DATA_LEN:   pay_len_d = byte_i - LEN_OVERHEAD;
        ST_SOURCE:     src_d = byte_i;
        ST_DEST:       dst_d = byte_i;
        ST_TYPE:       typ_d = byte_i;
        ST_PRIORITY:   prio_d = byte_i;
        ST_PAYLOAD:    cnt_d = cnt_inc;
        default:       ;
      endcase
    end
  end

  // Result
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      case (st_q)
        ST_REPLY_LEN: begin
          if (reply_big) begin
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_REPLY_DROP;
            res_o.reply_opcode = opcode_q;
          end
        end
        ST_REPLY_DATA: begin
          if (cnt_inc >= rep_len_q) begin
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_REPLY_DONE;
            res_o.reply_opcode = opcode_q;
            if (opcode_q == READ_OPCODE) begin
              res_o.read_valid = 1'b1;
              res_o.read_value = third_d;
            end
          end
        end
        ST_PAYLOAD: begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.source_id    = src_q;
          res_o.dest_id      = dst_q;
          res_o.msg_type     = typ_q;
          res_o.msg_priority = prio_q;
          res_o.payload_byte = byte_i;
          res_o.last_byte    = cnt_inc >= pay_len_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      pay_len_q <= '0;
      rep_len_q <= '0;
      opcode_q  <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      typ_q     <= '0;
      prio_q    <= '0;
      third_q   <= '0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      pay_len_q <= pay_len_d;
      rep_len_q <= rep_len_d;
      opcode_q  <= opcode_d;
      src_q     <= src_d;
      dst_q     <= dst_d;
      typ_q     <= typ_d;
      prio_q    <= prio_d;
      third_q   <= third_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rmfp_out_reg.sv @@
`default_nettype none

module rmfp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire rmfp_pkg::result_t res_i,
  input  wire logic              out_ready_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  output rmfp_pkg::result_t      out_o
);
  import rmfp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // Free when empty or when the held transaction leaves this cycle.
  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i)           valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/radio_module_frame_parser_unit.sv @@
// Channel   Dir  Payload                                           Handshake
// rx_i      in   rx_byte                                           valid/ready
// res_o     out  kind, header ids, payload/last, reply fields      valid/ready
//
// One byte per cycle while rx_i.ready is high; each byte updates the parser in the cycle it is taken.
// A result shows on res_o the cycle after its byte; one output register.
// rx_i.ready is low only while a result is held and res_o.ready is low.
// Reset clears the parser to idle and all held header bytes to zero.
`default_nettype none

module radio_module_frame_parser_unit #(
  parameter int unsigned REPLY_BUFFER_BYTES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rmfp_rx_if.sink   rx_i,
  rmfp_res_if.source res_o
);
  import rmfp_pkg::*;

  logic    accept;
  logic    space;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign rx_i.ready = space;
  assign accept     = rx_i.valid && space;

  rmfp_parser #(
    .REPLY_BUFFER_BYTES(REPLY_BUFFER_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (rx_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rmfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (res_o.ready),
    .space_o     (space),
    .out_valid_o (res_o.valid),
    .out_o       (out_data)
  );

  assign res_o.kind         = out_data.kind;
  assign res_o.source_id    = out_data.source_id;
  assign res_o.dest_id      = out_data.dest_id;
  assign res_o.msg_type     = out_data.msg_type;
  assign res_o.msg_priority = out_data.msg_priority;
  assign res_o.payload_byte = out_data.payload_byte;
  assign res_o.last_byte    = out_data.last_byte;
  assign res_o.reply_opcode = out_data.reply_opcode;
  assign res_o.read_valid   = out_data.read_valid;
  assign res_o.read_value   = out_data.read_value;

`include "radio_module_frame_parser_unit_assert.svh"

  `RMFP_ASSERT(a_stall_blocks_rx, clk_i, rst_ni, !(res_o.valid && !res_o.ready && rx_i.ready))
  `RMFP_ASSERT(a_payload_clean, clk_i, rst_ni, !(res_o.valid && res_o.kind == KIND_PAYLOAD && (res_o.reply_opcode != 8'd0 || res_o.read_valid)))
  `RMFP_ASSERT(a_read_is_done, clk_i, rst_ni, !(res_o.valid && res_o.read_valid && (res_o.kind != KIND_REPLY_DONE || res_o.reply_opcode != READ_OPCODE)))
  `RMFP_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, res_valid, res_o.valid)

endmodule

`default_nettype wire

@@ verif/rmfp_result_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmfp_result_checker #(
  parameter int unsigned REPLY_BUFFER_BYTES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rmfp_rx_if        rx_mon,
  rmfp_res_if       res_mon,
  output int        fail_count_o,
  output int        pending_o
);
  import rmfp_pkg::*;

  // Shadow copy of the parser
  parse_state_e frame_state;
  logic [7:0]   rx_count;
  logic [7:0]   payload_len;
  logic [7:0]   reply_len;
  logic [7:0]   reply_op;
  logic [7:0]   hdr_src;
  logic [7:0]   hdr_dst;
  logic [7:0]   hdr_type;
  logic [7:0]   hdr_prio;
  logic [7:0]   read_hold;

  int fail_cnt = 0;

  result_t expected_results[$];

  assign fail_count_o = fail_cnt;

  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    bit hit;
    hit = 1'b0;
    r   = '0;
    case (frame_state)
      ST_IDLE: begin
        if (b == START_BYTE) begin
          rx_count    = 8'd0;
          frame_state = ST_OPCODE;
        end
      end
      ST_OPCODE: begin
        if (b == DATA_OPCODE) begin
          frame_state = ST_DATA_LEN;
        end else begin
          reply_op    = b;
          frame_state = ST_REPLY_LEN;
        end
      end
      ST_REPLY_LEN: begin
        // reply too long for the receive buffer: drop it and skip to the checksum
        if (int'(b) + int'(REPLY_HEADER_BYTES) > int'(REPLY_BUFFER_BYTES)) begin
          r.kind         = KIND_REPLY_DROP;
          r.reply_opcode = reply_op;
          hit            = 1'b1;
          frame_state    = ST_CHECK;
        end else begin
          reply_len   = b;
          frame_state = (b != 8'd0) ? ST_REPLY_DATA : ST_CHECK;
        end
      end
      ST_REPLY_DATA: begin
        if (rx_count == READ_BYTE_INDEX) read_hold = b;
        rx_count = rx_count + 8'd1;
        if (rx_count >= reply_len) begin
          r.kind         = KIND_REPLY_DONE;
          r.reply_opcode = reply_op;
          // read value sticks across frames, so short read replies return a stale byte
          if (reply_op == READ_OPCODE) begin
            r.read_valid = 1'b1;
            r.read_value = read_hold;
          end
          hit         = 1'b1;
          frame_state = ST_CHECK;
        end
      end
      ST_DATA_LEN: begin
        payload_len = b - LEN_OVERHEAD;
        frame_state = ST_SOURCE;
      end
      ST_SOURCE: begin
        hdr_src     = b;
        frame_state = ST_DEST;
      end
      ST_DEST: begin
        hdr_dst     = b;
        frame_state = ST_TYPE;
      end
      ST_TYPE: begin
        hdr_type    = b;
        frame_state = ST_PRIORITY;
      end
      ST_PRIORITY: begin
        hdr_prio    = b;
        frame_state = (payload_len != 8'd0) ? ST_PAYLOAD : ST_STRENGTH;
      end
      ST_PAYLOAD: begin
        rx_count       = rx_count + 8'd1;
        r.kind         = KIND_PAYLOAD;
        r.source_id    = hdr_src;
        r.dest_id      = hdr_dst;
        r.msg_type     = hdr_type;
        r.msg_priority = hdr_prio;
        r.payload_byte = b;
        if (rx_count >= payload_len) begin
          r.last_byte = 1'b1;
          frame_state = ST_STRENGTH;
        end
        hit = 1'b1;
      end
      ST_STRENGTH: frame_state = ST_CHECK;
      ST_CHECK:    frame_state = ST_IDLE;
      default:     frame_state = ST_IDLE;
    endcase
    return hit;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    result_t exp_r;
    if (!rst_ni) begin
      frame_state = ST_IDLE;
      rx_count    = '0;
      payload_len = '0;
      reply_len   = '0;
      reply_op    = '0;
      hdr_src     = '0;
      hdr_dst     = '0;
      hdr_type    = '0;
      hdr_prio    = '0;
      read_hold   = '0;
      expected_results.delete();
      pending_o   = 0;
    end else begin
      if (rx_mon.valid && rx_mon.ready) begin
        if (parse_byte(rx_mon.rx_byte, r)) expected_results.push_back(r);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation pending (kind %0d)", res_mon.kind);
          fail_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("kind",         8'(exp_r.kind),     8'(res_mon.kind));
          check_field("source_id",    exp_r.source_id,    res_mon.source_id);
          check_field("dest_id",      exp_r.dest_id,      res_mon.dest_id);
          check_field("msg_type",     exp_r.msg_type,     res_mon.msg_type);
          check_field("msg_priority", exp_r.msg_priority, res_mon.msg_priority);
          check_field("payload_byte", exp_r.payload_byte, res_mon.payload_byte);
          check_field("last_byte",    8'(exp_r.last_byte), 8'(res_mon.last_byte));
          check_field("reply_opcode", exp_r.reply_opcode, res_mon.reply_opcode);
          check_field("read_valid",   8'(exp_r.read_valid), 8'(res_mon.read_valid));
          check_field("read_value",   exp_r.read_value,   res_mon.read_value);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

`default_nettype wire

@@ verif/radio_module_frame_parser_unit_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none

module radio_module_frame_parser_unit_tb;
  import rmfp_pkg::*;

  localparam int unsigned BUF_BYTES    = 16;
  localparam int          PHASE_ITEMS  = 325;

  logic clk_i = 1'b0;
  logic rst_ni;

  int idle_pct;
  int stall_pct;
  int frame_bytes_sent;
  int fail_count;
  int pending;

  rmfp_rx_if  rx_if ();
  rmfp_res_if res_if ();

  radio_module_frame_parser_unit #(
    .REPLY_BUFFER_BYTES(BUF_BYTES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  rmfp_result_checker #(
    .REPLY_BUFFER_BYTES(BUF_BYTES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_mon      (rx_if),
    .res_mon     (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // one byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    if (counted) frame_bytes_sent++;
  endtask

  task automatic send_data_frame();
    logic [7:0] len_byte;
    logic [7:0] n_payload;
    len_byte = ($urandom_range(99) < 5) ? 8'($urandom_range(255))
                                        : LEN_OVERHEAD + 8'($urandom_range(8));
    n_payload = len_byte - LEN_OVERHEAD;
    send_byte(START_BYTE, 1'b1);
    send_byte(DATA_OPCODE, 1'b1);
    send_byte(len_byte, 1'b1);
    repeat (4) send_byte(8'($urandom_range(255)), 1'b1);
    repeat (n_payload) send_byte(8'($urandom_range(255)), 1'b1);
    repeat (2) send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_reply();
    logic [7:0] op;
    logic [7:0] len_byte;
    op = ($urandom_range(99) < 30) ? READ_OPCODE : 8'($urandom_range(255));
    if (op == DATA_OPCODE) op = READ_OPCODE;
    len_byte = ($urandom_range(99) < 10) ? 8'($urandom_range(255, BUF_BYTES - 3))
                                         : 8'($urandom_range(BUF_BYTES - REPLY_HEADER_BYTES));
    send_byte(START_BYTE, 1'b1);
    send_byte(op, 1'b1);
    send_byte(len_byte, 1'b1);
    if (int'(len_byte) + int'(REPLY_HEADER_BYTES) <= int'(BUF_BYTES))
      repeat (len_byte) send_byte(8'($urandom_range(255)), 1'b1);
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_random_frame();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_data_frame();
    end else if (pick < 80) begin
      send_reply();
    end else if (pick < 90) begin
      // line noise between frames; the parser should ignore it while idle
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom_range(255));
        if (b == START_BYTE) b = ~START_BYTE;
        send_byte(b, 1'b0);
      end
    end else begin
      // truncated frame: the following bytes get parsed as its continuation
      send_byte(START_BYTE, 1'b1);
      repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    logic [7:0] seq[$];
    rst_ni           = 1'b0;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    frame_bytes_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short read right after reset, data frame with extreme header and payload,
    // full read reply, oversize reply, empty reply
    seq = '{START_BYTE, READ_OPCODE, 8'h01, 8'h55, 8'hc3,
            START_BYTE, DATA_OPCODE, 8'h07, 8'h00, 8'hff, 8'h80, 8'h7f, 8'h00, 8'hff,
            8'h40, 8'h12,
            START_BYTE, READ_OPCODE, 8'h03, 8'h11, 8'h22, 8'h33, 8'h99,
            START_BYTE, READ_OPCODE, 8'h0d, 8'h00,
            START_BYTE, 8'h20, 8'h00, 8'hee};
    foreach (seq[i]) send_byte(seq[i], 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      while (frame_bytes_sent < PHASE_ITEMS * (phase + 1)) send_random_frame();
    end

    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rmfp_pkg.sv
rtl/core/rmfp_intf.sv
rtl/core/rmfp_parser.sv
rtl/core/rmfp_out_reg.sv
rtl/core/radio_module_frame_parser_unit.sv
verif/rmfp_result_checker.sv
verif/radio_module_frame_parser_unit_tb.sv
